// File: design/grbs_pkg.sv
// ----------------------------------------------------------------------------
// grbs_pkg
// shared types, constants and helpers of the glyph bitmap span rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package grbs_pkg;

    localparam int unsigned COORD_W         = 16;
    localparam int unsigned PIX_W           = 8;
    localparam int unsigned SPAN_LEN_W      = 4;
    localparam int unsigned JOB_QUEUE_DEPTH = 4;
    localparam int unsigned JOB_PTR_W       = $clog2(JOB_QUEUE_DEPTH);
    localparam int unsigned JOB_CNT_W       = $clog2(JOB_QUEUE_DEPTH + 1);

    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned M_TDATA_W = 40;

    // one classified byte waiting for span extraction
    typedef struct packed {
        logic [PIX_W-1:0]   bits;    // in-width pixels, bit 7 leftmost
        logic [COORD_W-1:0] base_x;  // pen_x + offset_x + column, raw
        logic [COORD_W-1:0] y;       // wrapped row coordinate
    } job_t;

    // keep the low coordinate bits up to sign_bit, sign-extend above
    function automatic logic [COORD_W-1:0] coord_wrap(
        input logic [COORD_W-1:0] s,
        input logic [3:0]         sign_bit
    );
        logic [COORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_W; i++) begin
            r[i] = (4'(i) <= sign_bit) ? s[i] : s[sign_bit];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/glyph_bitmap_span_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_span_rasterizer_unit
// turns 1bpp glyph bitmap bytes into one-pixel-high filled spans
// ----------------------------------------------------------------------------
// usage
//   s_* carries one bitmap byte per transfer, row-major, bit 7 leftmost, each
//   glyph row starting on a new byte; s_tuser marks the first byte of a glyph
//   m_* carries one span per transfer; m_tlast marks the last span of a byte
//   a byte with no set pixel inside the glyph width, or past the glyph
//   height, gives no transfer on m_*
// path
//   a taken byte is written into the job queue, then its first span into the
//   output register; later spans follow one per cycle while m_tready is high
// throughput
//   one input byte per cycle while the 4-entry job queue has room; the span
//   extractor emits one span per cycle while m_tready is high, one per run of
//   set pixels of a byte, at most four
// reset
//   aresetn low clears column and row, empties the queue, drops m_tvalid
// stall
//   with m_tready low the current span holds; the queue keeps filling and
//   s_tready drops only when it is full
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_bitmap_span_rasterizer_unit
    import grbs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input byte channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pen_x, pen_y, glyph_offset_x, glyph_offset_y, glyph_width,
    // glyph_height, bitmap_byte
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // first_byte
    input  wire logic                 s_tuser,
    // span channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // span_x, span_y, span_length, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    // last_span
    output logic                      m_tlast
);

    // front to queue
    logic push;
    job_t push_job;

    // queue to back end
    logic queue_full;
    logic queue_empty;
    logic pop;
    job_t head;

    // classify each byte, track position, mask padding pixels
    grbs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // decouples byte intake from span output
    grbs_job_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head)
    );

    // one span per cycle into the output register while m_tready is high
    grbs_span_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// File: design/grbs_front.sv
// ----------------------------------------------------------------------------
// grbs_front
// accepts bitmap bytes, tracks column and row, masks padding, queues jobs
// ----------------------------------------------------------------------------
`default_nettype none

module grbs_front
    import grbs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 queue_full,
    output logic                      push,
    output job_t                      push_job
);

    localparam logic [3:0] SignBit = (COORD_BITS < 16) ? 4'(COORD_BITS - 1) : 4'd15;

    logic [PIX_W-1:0] column_reg, column_next;
    logic [PIX_W-1:0] row_reg, row_next;

    logic [COORD_W-1:0] pen_x, pen_y, off_x, off_y;
    logic [PIX_W-1:0]   width, height, bitmap;
    logic               fire;
    logic [PIX_W-1:0]   col_eff, row_eff;
    logic               past_height;
    logic [3:0]         n_pix;
    logic [PIX_W-1:0]   masked;
    logic [PIX_W:0]     col_plus;

    assign pen_x  = s_tdata[15:0];
    assign pen_y  = s_tdata[31:16];
    assign off_x  = s_tdata[47:32];
    assign off_y  = s_tdata[63:48];
    assign width  = s_tdata[71:64];
    assign height = s_tdata[79:72];
    assign bitmap = s_tdata[87:80];

    assign s_tready = !queue_full;
    assign fire     = s_tvalid && s_tready;

    always_comb begin
        col_eff     = s_tuser ? '0 : column_reg;
        row_eff     = s_tuser ? '0 : row_reg;
        past_height = (row_eff >= height);
        if (width > col_eff) begin
            n_pix = ((width - col_eff) > 8'd8) ? 4'd8 : 4'(width - col_eff);
        end else begin
            n_pix = 4'd0;
        end
        masked   = bitmap & ~(8'hFF >> n_pix);
        col_plus = {1'b0, col_eff} + 9'd8;
    end

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        if (fire) begin
            column_next = col_eff;
            row_next    = row_eff;
            if (!past_height) begin
                if (col_plus >= {1'b0, width}) begin
                    column_next = '0;
                    row_next    = row_eff + 8'd1;
                end else begin
                    column_next = col_plus[PIX_W-1:0];
                end
            end
        end
    end

    always_comb begin
        push            = fire && !past_height && (masked != '0);
        push_job.bits   = masked;
        push_job.base_x = pen_x + off_x + {8'd0, col_eff};
        push_job.y      = coord_wrap(pen_y + off_y + {8'd0, row_eff}, SignBit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: design/grbs_job_queue.sv
// ----------------------------------------------------------------------------
// grbs_job_queue
// small register queue between the classifying front and the span back end
// ----------------------------------------------------------------------------
`default_nettype none

module grbs_job_queue
    import grbs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output job_t      head
);

    job_t                 entry_reg [JOB_QUEUE_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full    = (count_reg == JOB_CNT_W'(JOB_QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= JOB_CNT_W'(JOB_QUEUE_DEPTH))
        else $error("job queue count exceeds depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0 && count_reg != JOB_CNT_W'(JOB_QUEUE_DEPTH))
            |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("job queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// File: design/grbs_span_back.sv
// ----------------------------------------------------------------------------
// grbs_span_back
// peels one run of set pixels per cycle off the queued byte into spans while the output is free
// ----------------------------------------------------------------------------
`default_nettype none

module grbs_span_back
    import grbs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 queue_empty,
    input  job_t                      head,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam logic [3:0] SignBit = (COORD_BITS < 16) ? 4'(COORD_BITS - 1) : 4'd15;

    logic                  busy_reg, busy_next;
    logic [PIX_W-1:0]      cur_bits_reg, cur_bits_next;
    logic [COORD_W-1:0]    cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]    cur_y_reg, cur_y_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]    span_x_reg, span_x_next;
    logic [COORD_W-1:0]    span_y_reg, span_y_next;
    logic [SPAN_LEN_W-1:0] span_len_reg, span_len_next;
    logic                  last_reg, last_next;

    logic                  src_valid, out_free, take;
    logic [PIX_W-1:0]      src_bits, shifted, run_mask, remaining;
    logic [COORD_W-1:0]    src_x, src_y;
    logic [2:0]            start;
    logic [SPAN_LEN_W-1:0] run_len;
    logic                  found, in_run;

    assign src_valid = busy_reg || !queue_empty;
    assign src_bits  = busy_reg ? cur_bits_reg : head.bits;
    assign src_x     = busy_reg ? cur_x_reg : head.base_x;
    assign src_y     = busy_reg ? cur_y_reg : head.y;
    assign out_free  = !out_valid_reg || m_tready;
    assign take      = out_free && src_valid;
    assign pop       = take && !busy_reg;

    // leftmost run: start at the first set pixel, count the consecutive ones from it
    always_comb begin
        start   = '0;
        found   = 1'b0;
        run_len = '0;
        in_run  = 1'b1;
        for (int i = 0; i < PIX_W; i++) begin
            if (!found && src_bits[PIX_W-1-i]) begin
                start = 3'(i);
                found = 1'b1;
            end
        end
        shifted = src_bits << start;
        for (int i = 0; i < PIX_W; i++) begin
            if (in_run && shifted[PIX_W-1-i]) begin
                run_len = run_len + 1'b1;
            end else begin
                in_run = 1'b0;
            end
        end
        run_mask  = (~(8'hFF >> run_len)) >> start;
        remaining = src_bits & ~run_mask;
    end

    always_comb begin
        busy_next      = busy_reg;
        cur_bits_next  = cur_bits_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        out_valid_next = out_valid_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        span_len_next  = span_len_reg;
        last_next      = last_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (take) begin
            busy_next      = (remaining != '0);
            cur_bits_next  = remaining;
            cur_x_next     = src_x;
            cur_y_next     = src_y;
            out_valid_next = 1'b1;
            span_x_next    = coord_wrap(src_x + {13'd0, start}, SignBit);
            span_y_next    = src_y;
            span_len_next  = run_len;
            last_next      = (remaining == '0);
        end
    end

    always_ff @(posedge aclk) begin
        cur_bits_reg <= cur_bits_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        span_x_reg   <= span_x_next;
        span_y_reg   <= span_y_next;
        span_len_reg <= span_len_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, span_len_reg, span_y_reg, span_x_reg};
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_busy_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> out_valid_reg)
        else $error("span back end busy without a pending span");

    a_busy_has_pixels: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cur_bits_reg != '0))
        else $error("span back end busy with no pixels left");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (span_len_reg != '0 && span_len_reg <= 4'd8))
        else $error("span length out of range");

    a_busy_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && busy_reg) |-> !last_reg)
        else $error("last span flagged while runs remain");
`endif

endmodule

`default_nettype wire
